/* sv/mpfl_pkg.sv */
// Package for the multi-pool free list allocator.
// Holds codes, widths, link store types and register reset values.
// No dependencies.
package mpfl_pkg;

  localparam int unsigned SlotW    = 8;
  localparam int unsigned LinkW    = 9;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned CfgCount = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PoolSelW = 2;
  localparam int unsigned PoolCntW = 3;
  localparam int unsigned SlotTotal = 256;

  // Bit 8 set marks the end of a chain or an empty pool.
  localparam logic [LinkW-1:0] LinkNull = 9'h100;

  localparam logic [CfgW-1:0] CfgReset [CfgCount] = '{7'd4, 7'd5, 7'd8, 7'd16};

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [LinkW-1:0] data;
  } link_wr_t;

endpackage

/* sv/multi_pool_free_list_allocator.sv */
// Top level of the multi-pool free list allocator: heads, sequencer, output register.
// Depends on mpfl_pkg and mpfl_link_ram.
//
//   channel   handshake                     payload
//   -------   ---------------------------   ------------------------------------
//   in        in_valid_i / in_ready_o       action_i pool_type_i has_block_i slot_in_i
//   out       out_valid_o / out_ready_i     status_o slot_out_o
//   cfg       cfg_we_i (no wait)            cfg_idx_i cfg_data_i
//
// Steps: free, null free, unused action and alloc from an empty or bad pool emit
//   their result in the cycle they are taken; a successful alloc reads the link of the
//   head slot in S_IDLE, then writes back head and link in S_READ.
// Init walks the pools in S_INIT over the n slots laid out for each pool:
//   the walker writes one link per cycle through the single write port.
// Reset clears heads to empty and loads the register defaults; the link store is
//   not cleared, so there is no clearing pass.
// A finished result waits in the output register; the next beat is taken while it
//   waits, and the block holds only if a second result finds the register full.
module multi_pool_free_list_allocator #(
  parameter int unsigned POOL_COUNT     = 4,
  parameter int unsigned POOL_MAX_SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [mpfl_pkg::PoolSelW-1:0]     pool_type_i,
  input  logic                              has_block_i,
  input  logic [mpfl_pkg::SlotW-1:0]        slot_in_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [mpfl_pkg::SlotW-1:0]        slot_out_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [mpfl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mpfl_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned PoolIdxW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam logic [mpfl_pkg::LinkW-1:0] MaxSlots = mpfl_pkg::LinkW'(POOL_MAX_SLOTS);
  localparam logic [mpfl_pkg::PoolCntW-1:0] LastPool = mpfl_pkg::PoolCntW'(POOL_COUNT - 1);
  localparam logic [mpfl_pkg::LinkW-1:0] SlotEnd = mpfl_pkg::LinkW'(mpfl_pkg::SlotTotal);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_INIT = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [mpfl_pkg::CfgW-1:0] cfg_q [mpfl_pkg::CfgCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mpfl_pkg::CfgCount; i++) begin
        cfg_q[i] <= mpfl_pkg::CfgReset[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // pool heads live in flops: few entries, one read place
  logic [mpfl_pkg::LinkW-1:0] heads_q [POOL_COUNT];
  logic                       head_we;
  logic [PoolIdxW-1:0]        head_widx;
  logic [mpfl_pkg::LinkW-1:0] head_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        heads_q[i] <= mpfl_pkg::LinkNull;
      end
    end else if (head_we) begin
      heads_q[head_widx] <= head_wdata;
    end
  end

  // link store
  mpfl_pkg::link_wr_t          link_wr;
  logic                        link_rd_en;
  logic [mpfl_pkg::LinkW-1:0]  link_rd_data;

  // item decode
  logic                        in_pool_ok;
  logic [PoolIdxW-1:0]         in_idx;
  logic [mpfl_pkg::LinkW-1:0]  in_head;

  assign in_pool_ok = 32'(pool_type_i) < POOL_COUNT;
  assign in_idx     = PoolIdxW'(pool_type_i);
  assign in_head    = in_pool_ok ? heads_q[in_idx] : mpfl_pkg::LinkNull;

  mpfl_link_ram u_link_ram (
    .clk_i     (clk_i),
    .wr_i      (link_wr),
    .rd_en_i   (link_rd_en),
    .rd_addr_i (in_head[mpfl_pkg::SlotW-1:0]),
    .rd_data_o (link_rd_data)
  );

  // alloc in flight
  logic [PoolIdxW-1:0]         alloc_idx_q, alloc_idx_d;
  logic [mpfl_pkg::SlotW-1:0]  alloc_slot_q, alloc_slot_d;

  // init walker: current pool, its first slot, the slot being linked
  logic [mpfl_pkg::PoolCntW-1:0] ini_pool_q, ini_pool_d;
  logic [mpfl_pkg::LinkW-1:0]    ini_base_q, ini_base_d;
  logic [mpfl_pkg::LinkW-1:0]    ini_addr_q, ini_addr_d;
  logic [mpfl_pkg::LinkW-1:0]    ini_req, ini_share, ini_room, ini_n, ini_end, ini_next;
  logic                          ini_pool_done;

  // clamp the register count, then cut it at the end of the slot space
  assign ini_req   = ini_pool_q[2] ? '0 : {2'b00, cfg_q[ini_pool_q[1:0]]};
  assign ini_share = (ini_req > MaxSlots) ? MaxSlots : ini_req;
  assign ini_room  = SlotEnd - ini_base_q;
  assign ini_n     = (ini_share > ini_room) ? ini_room : ini_share;
  assign ini_end   = ini_base_q + ini_n;
  assign ini_next  = ini_addr_q + 9'd1;
  assign ini_pool_done = (ini_n == '0) || (ini_next == ini_end);

  // result path
  logic                        emit;
  logic [1:0]                  res_status;
  logic [mpfl_pkg::SlotW-1:0]  res_slot;
  logic [1:0]                  res_status_q, res_status_d;
  logic [mpfl_pkg::SlotW-1:0]  res_slot_q, res_slot_d;
  logic                        out_free, out_load;
  logic [1:0]                  out_status;
  logic [mpfl_pkg::SlotW-1:0]  out_slot;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [mpfl_pkg::SlotW-1:0]  slot_out_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    emit         = 1'b0;
    res_status   = mpfl_pkg::ST_OK;
    res_slot     = '0;
    link_wr      = '0;
    link_rd_en   = 1'b0;
    head_we      = 1'b0;
    head_widx    = in_idx;
    head_wdata   = mpfl_pkg::LinkNull;
    alloc_idx_d  = alloc_idx_q;
    alloc_slot_d = alloc_slot_q;
    ini_pool_d   = ini_pool_q;
    ini_base_d   = ini_base_q;
    ini_addr_d   = ini_addr_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_load     = 1'b0;
    out_status   = res_status_q;
    out_slot     = res_slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            mpfl_pkg::ACT_INIT: begin
              ini_pool_d = '0;
              ini_base_d = '0;
              ini_addr_d = '0;
              state_d    = S_INIT;
            end
            mpfl_pkg::ACT_ALLOC: begin
              if (in_head[mpfl_pkg::LinkW-1]) begin
                emit       = 1'b1;
                res_status = mpfl_pkg::ST_EMPTY;
              end else begin
                // fetch the head's link; pop it next cycle
                link_rd_en   = 1'b1;
                alloc_idx_d  = in_idx;
                alloc_slot_d = in_head[mpfl_pkg::SlotW-1:0];
                state_d      = S_READ;
              end
            end
            mpfl_pkg::ACT_FREE: begin
              emit = 1'b1;
              if (!has_block_i || !in_pool_ok) begin
                res_status = mpfl_pkg::ST_IGNORED;
              end else begin
                // push: freed slot points at the old head and becomes the head
                link_wr.en   = 1'b1;
                link_wr.addr = slot_in_i;
                link_wr.data = in_head;
                head_we      = 1'b1;
                head_wdata   = {1'b0, slot_in_i};
              end
            end
            default: begin
              emit       = 1'b1;
              res_status = mpfl_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_READ: begin
        head_we      = 1'b1;
        head_widx    = alloc_idx_q;
        head_wdata   = link_rd_data;
        link_wr.en   = 1'b1;
        link_wr.addr = alloc_slot_q;
        link_wr.data = mpfl_pkg::LinkNull;
        emit         = 1'b1;
        res_slot     = alloc_slot_q;
      end
      S_INIT: begin
        head_we    = 1'b1;
        head_widx  = PoolIdxW'(ini_pool_q);
        head_wdata = (ini_n == '0) ? mpfl_pkg::LinkNull
                                   : {1'b0, ini_base_q[mpfl_pkg::SlotW-1:0]};
        if (ini_n != '0) begin
          link_wr.en   = 1'b1;
          link_wr.addr = ini_addr_q[mpfl_pkg::SlotW-1:0];
          link_wr.data = (ini_next < ini_end) ? {1'b0, ini_next[mpfl_pkg::SlotW-1:0]}
                                              : mpfl_pkg::LinkNull;
          ini_addr_d   = ini_next;
        end
        if (ini_pool_done) begin
          ini_base_d = ini_end;
          ini_addr_d = ini_end;
          ini_pool_d = ini_pool_q + 3'd1;
          if (ini_pool_q == LastPool) begin
            emit = 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand the result to the output register, or park it if that is full
    if (emit) begin
      if (out_free) begin
        out_load   = 1'b1;
        out_status = res_status;
        out_slot   = res_slot;
        state_d    = S_IDLE;
      end else begin
        res_status_d = res_status;
        res_slot_d   = res_slot;
        state_d      = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ini_pool_q  <= '0;
      ini_base_q  <= '0;
      ini_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      ini_pool_q <= ini_pool_d;
      ini_base_q <= ini_base_d;
      ini_addr_q <= ini_addr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_idx_q  <= alloc_idx_d;
    alloc_slot_q <= alloc_slot_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      status_q   <= out_status;
      slot_out_q <= out_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_out_q;

endmodule

/* sv/mpfl_link_ram.sv */
// Link store: one next-slot link per slot, one write and one read port.
// Read data is registered. Uses mpfl_pkg.
module mpfl_link_ram (
  input  logic                              clk_i,
  input  mpfl_pkg::link_wr_t                wr_i,
  input  logic                              rd_en_i,
  input  logic [mpfl_pkg::SlotW-1:0]        rd_addr_i,
  output logic [mpfl_pkg::LinkW-1:0]        rd_data_o
);

  logic [mpfl_pkg::LinkW-1:0] mem [mpfl_pkg::SlotTotal];
  logic [mpfl_pkg::LinkW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/mpfl_checker.sv */
// Port-level checks for the multi-pool free list allocator, and their bind.
// Depends on mpfl_pkg; attaches to multi_pool_free_list_allocator.
module mpfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [1:0]                    action_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [mpfl_pkg::SlotW-1:0]    slot_out_o
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_out_o))
    else $error("result beat changed while stalled");

  // only a successful alloc carries a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != mpfl_pkg::ST_OK) |-> slot_out_o == '0)
    else $error("slot reported on a failed request");

  // init walks the link store, so the input side is busy right after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == mpfl_pkg::ACT_INIT) |=> !in_ready_o)
    else $error("input taken during init walk");

  // no result out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind multi_pool_free_list_allocator mpfl_checker u_mpfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .slot_out_o  (slot_out_o)
);

/* test/multi_pool_free_list_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for multi_pool_free_list_allocator: directed requests, then
// random alloc/free traffic over several pool layouts. Depends on mpfl_pkg and the RTL.

// Shadow copy of the pool heads, slot links and pool counts. Each accepted request
// is turned into the grant the block must return; grants are checked in order.
class free_list_tracker;
  typedef struct packed {
    mpfl_pkg::status_e          status;
    logic [mpfl_pkg::SlotW-1:0] slot;
  } grant_t;

  int unsigned                pool_total;
  int unsigned                slot_cap;
  logic [mpfl_pkg::LinkW-1:0] heads[4];
  logic [mpfl_pkg::LinkW-1:0] links[mpfl_pkg::SlotTotal];
  logic [mpfl_pkg::CfgW-1:0]  counts[mpfl_pkg::CfgCount];
  grant_t                     pending_grants[$];
  logic [mpfl_pkg::SlotW-1:0] held_slots[$];
  int unsigned                failures;

  function new(int unsigned pools, int unsigned cap);
    pool_total = pools;
    slot_cap   = cap;
    failures   = 0;
    foreach (heads[p]) heads[p] = mpfl_pkg::LinkNull;
    foreach (links[s]) links[s] = '0;
    foreach (counts[r]) counts[r] = mpfl_pkg::CfgReset[r];
  endfunction

  function void write_count(int unsigned idx, logic [mpfl_pkg::CfgW-1:0] value);
    if (idx < mpfl_pkg::CfgCount) counts[idx] = value;
  endfunction

  // Chain each pool's share back to back; counts above the cap are clamped and the
  // layout stops at the last slot.
  function void lay_out();
    int unsigned base;
    int unsigned n;
    base = 0;
    for (int p = 0; p < pool_total; p++) begin
      n = (p < mpfl_pkg::CfgCount) ? counts[p] : 0;
      if (n > slot_cap) n = slot_cap;
      if (n > mpfl_pkg::SlotTotal - base) n = mpfl_pkg::SlotTotal - base;
      if (n == 0) begin
        heads[p] = mpfl_pkg::LinkNull;
      end else begin
        heads[p] = mpfl_pkg::LinkW'(base);
        for (int j = 0; j + 1 < n; j++) links[base + j] = mpfl_pkg::LinkW'(base + j + 1);
        links[base + n - 1] = mpfl_pkg::LinkNull;
        base += n;
      end
    end
  endfunction

  function void note_request(logic [1:0] act, logic [1:0] pool, logic has_block,
                             logic [mpfl_pkg::SlotW-1:0] slot);
    grant_t                     g;
    logic [mpfl_pkg::LinkW-1:0] h;
    g.status = mpfl_pkg::ST_OK;
    g.slot   = '0;
    case (act)
      mpfl_pkg::ACT_INIT: begin
        lay_out();
        held_slots.delete();
      end
      mpfl_pkg::ACT_ALLOC: begin
        h = heads[pool];
        if (pool >= pool_total || h[mpfl_pkg::LinkW-1]) begin
          g.status = mpfl_pkg::ST_EMPTY;
        end else begin
          heads[pool]      = links[h[mpfl_pkg::SlotW-1:0]];
          links[h[mpfl_pkg::SlotW-1:0]] = mpfl_pkg::LinkNull;
          g.slot           = h[mpfl_pkg::SlotW-1:0];
          held_slots.push_back(h[mpfl_pkg::SlotW-1:0]);
        end
      end
      mpfl_pkg::ACT_FREE: begin
        if (!has_block || pool >= pool_total) begin
          g.status = mpfl_pkg::ST_IGNORED;
        end else begin
          links[slot] = heads[pool];
          heads[pool] = {1'b0, slot};
        end
      end
      default: g.status = mpfl_pkg::ST_IGNORED;
    endcase
    pending_grants.push_back(g);
  endfunction

  function void check_grant(logic [1:0] status, logic [mpfl_pkg::SlotW-1:0] slot);
    grant_t g;
    if (pending_grants.size() == 0) begin
      $error("unexpected result beat: status %0d slot_out %0d", status, slot);
      failures++;
      return;
    end
    g = pending_grants.pop_front();
    if (status !== g.status) begin
      $error("status: expected %0d, got %0d", g.status, status);
      failures++;
    end
    if (slot !== g.slot) begin
      $error("slot_out: expected %0d, got %0d", g.slot, slot);
      failures++;
    end
  endfunction
endclass

module multi_pool_free_list_allocator_test;

  localparam int unsigned PoolCount    = 4;
  localparam int unsigned PoolMaxSlots = 64;
  localparam logic [1:0]  ActUnused    = 2'd3;
  localparam int unsigned PhaseCount   = 9;
  localparam int unsigned PhaseItems   = 200;
  localparam int unsigned QuietLimit   = 4000;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    action_i    = '0;
  logic [mpfl_pkg::PoolSelW-1:0] pool_type_i = '0;
  logic                          has_block_i = 1'b0;
  logic [mpfl_pkg::SlotW-1:0]    slot_in_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    status_o;
  logic [mpfl_pkg::SlotW-1:0]    slot_out_o;
  logic                          cfg_we_i    = 1'b0;
  logic [mpfl_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [mpfl_pkg::CfgW-1:0]     cfg_data_i  = '0;

  free_list_tracker tracker = new(PoolCount, PoolMaxSlots);

  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 54;
  int unsigned quiet_cycles  = 0;

  multi_pool_free_list_allocator #(
    .POOL_COUNT    (PoolCount),
    .POOL_MAX_SLOTS(PoolMaxSlots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .pool_type_i(pool_type_i),
    .has_block_i(has_block_i),
    .slot_in_i  (slot_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .slot_out_o (slot_out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random; the rate follows the current idling phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every result beat against the oldest pending grant.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_grant(status_o, slot_out_o);
  end

  // Count cycles in which neither channel moves a beat; give up after the limit.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted. Call right after a rising edge;
  // returns on the edge that took the beat, with valid still high.
  task automatic send_request(logic [1:0] act, logic [1:0] pool, logic has_block,
                              logic [mpfl_pkg::SlotW-1:0] slot);
    // Idling phases: sender-light first, then receiver-light, then none at all.
    if (items_sent < 600) begin
      send_idle_pct = 13;
      recv_idle_pct = 54;
    end else if (items_sent < 1200) begin
      send_idle_pct = 54;
      recv_idle_pct = 13;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    pool_type_i <= pool;
    has_block_i <= has_block;
    slot_in_i   <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(act, pool, has_block, slot);
    items_sent++;
  endtask

  // Drop valid and hold off until every pending grant has come back.
  task automatic drain_grants();
    in_valid_i <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four pool counts, one register per cycle. Only call while idle.
  task automatic write_counts(logic [mpfl_pkg::CfgW-1:0] c0, logic [mpfl_pkg::CfgW-1:0] c1,
                              logic [mpfl_pkg::CfgW-1:0] c2, logic [mpfl_pkg::CfgW-1:0] c3);
    logic [mpfl_pkg::CfgW-1:0] vals[mpfl_pkg::CfgCount];
    vals = '{c0, c1, c2, c3};
    for (int r = 0; r < mpfl_pkg::CfgCount; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= mpfl_pkg::CfgIdxW'(r);
      cfg_data_i <= vals[r];
      @(posedge clk_i);
      tracker.write_count(r, vals[r]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly allocs and frees of slots handed out earlier, with a mix of stray frees,
  // null frees, the unused action and the odd re-init.
  task automatic random_request();
    int unsigned                pick;
    int unsigned                idx;
    logic [mpfl_pkg::SlotW-1:0] slot;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_request(mpfl_pkg::ACT_INIT, 2'($urandom), 1'($urandom), 8'($urandom));
    end else if (pick < 45) begin
      send_request(mpfl_pkg::ACT_ALLOC, 2'($urandom), 1'($urandom), 8'($urandom));
    end else if (pick < 80 && tracker.held_slots.size() != 0) begin
      idx  = $urandom_range(tracker.held_slots.size() - 1);
      slot = tracker.held_slots[idx];
      tracker.held_slots.delete(idx);
      send_request(mpfl_pkg::ACT_FREE, 2'($urandom), 1'b1, slot);
    end else if (pick < 88) begin
      send_request(mpfl_pkg::ACT_FREE, 2'($urandom), 1'b1, 8'($urandom));
    end else if (pick < 94) begin
      send_request(mpfl_pkg::ACT_FREE, 2'($urandom), 1'b0, 8'($urandom));
    end else begin
      send_request(ActUnused, 2'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [mpfl_pkg::CfgW-1:0] layouts[5][mpfl_pkg::CfgCount];
    logic [mpfl_pkg::CfgW-1:0] c[mpfl_pkg::CfgCount];
    layouts = '{'{7'd127, 7'd0, 7'd64, 7'd64}, '{7'd0, 7'd0, 7'd0, 7'd0},
                '{7'd64, 7'd64, 7'd64, 7'd64}, '{7'd127, 7'd127, 7'd127, 7'd127},
                '{7'd1, 7'd1, 7'd1, 7'd1}};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset-time pool counts.
    send_request(mpfl_pkg::ACT_ALLOC, 2'd0, 1'b0, 8'd0);   // every pool empty before init
    send_request(mpfl_pkg::ACT_FREE, 2'd1, 1'b0, 8'hFF);   // null free
    send_request(ActUnused, 2'd3, 1'b1, 8'hAA);            // unused action
    send_request(mpfl_pkg::ACT_INIT, 2'd0, 1'b0, 8'd0);
    repeat (5) send_request(mpfl_pkg::ACT_ALLOC, 2'd0, 1'b0, 8'd0);  // run pool 0 dry
    send_request(mpfl_pkg::ACT_FREE, 2'd0, 1'b1, 8'hFF);   // top slot, never laid out
    send_request(mpfl_pkg::ACT_ALLOC, 2'd0, 1'b0, 8'd0);
    send_request(mpfl_pkg::ACT_ALLOC, 2'd1, 1'b1, 8'h55);
    send_request(mpfl_pkg::ACT_ALLOC, 2'd2, 1'b0, 8'd0);
    send_request(mpfl_pkg::ACT_ALLOC, 2'd3, 1'b0, 8'd0);
    send_request(mpfl_pkg::ACT_FREE, 2'd3, 1'b1, 8'd0);    // slot of pool 0 into pool 3
    send_request(mpfl_pkg::ACT_ALLOC, 2'd3, 1'b0, 8'd0);
    send_request(mpfl_pkg::ACT_FREE, 2'd2, 1'b1, 8'h55);
    send_request(mpfl_pkg::ACT_FREE, 2'd2, 1'b1, 8'h55);   // same slot freed twice
    send_request(mpfl_pkg::ACT_FREE, 2'd2, 1'b0, 8'h55);
    send_request(mpfl_pkg::ACT_INIT, 2'd3, 1'b1, 8'hFF);   // re-init over live lists
    send_request(mpfl_pkg::ACT_ALLOC, 2'd3, 1'b0, 8'd0);

    // Random part: one pool layout per phase, extremes first.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_grants();
      if (ph < 5) begin
        c = layouts[ph];
      end else begin
        foreach (c[r]) c[r] = ($urandom_range(3) == 0)
                              ? mpfl_pkg::CfgW'($urandom_range(127))
                              : mpfl_pkg::CfgW'($urandom_range(12));
      end
      write_counts(c[0], c[1], c[2], c[3]);
      send_request(mpfl_pkg::ACT_INIT, 2'($urandom), 1'($urandom), 8'($urandom));
      repeat (PhaseItems) random_request();
    end

    drain_grants();
    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
